/* design/best_fit_heap_allocator_core_defines.svh */
// ----------------------------------------------------------------------------
// Best-fit heap allocator: assertion macros
// Shared concurrent assertion wrappers for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Assert a property on an explicit clock and active-low reset
`define BFHA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the default clock and reset of the module
`define BFHA_ASSERT(lbl, prop, msg) \
  `BFHA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* design/bfha_pkg.sv */
// ----------------------------------------------------------------------------
// Best-fit heap allocator package
// Shared constants, codes and the block table entry type.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned MAX_BLOCKS_DEF      = 64;
  localparam int unsigned HEADER_BYTES_DEF    = 24;
  localparam int unsigned ALIGN_BYTES_DEF     = 16;
  localparam int unsigned MIN_BLOCK_BYTES_DEF = 16;

  localparam int unsigned SizeW = 24;
  localparam int unsigned AddrW = 32;
  localparam logic [SizeW-1:0] HeapBytesRst = 24'd1048576;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  // one block table entry
  typedef struct packed {
    logic [SizeW-1:0] off;
    logic [SizeW-1:0] size;
    logic             used;
  } ent_t;

endpackage

/* design/bfha_mem.sv */
// ----------------------------------------------------------------------------
// Best-fit heap allocator block table
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module bfha_mem #(
  parameter int unsigned MaxBlocks = bfha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MaxBlocks)-1:0] waddr_i,
  input  bfha_pkg::ent_t               wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(MaxBlocks)-1:0] raddr_i,
  output bfha_pkg::ent_t               rdata_o
);
  import bfha_pkg::*;

  ent_t mem_q [MaxBlocks];
  ent_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/best_fit_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// Best-fit heap allocator core
// Address-ordered block table with best-fit allocate and coalescing free.
// ----------------------------------------------------------------------------
// Usage: drive operation_i, req_bytes_i and address_i with start high; the
// beat is taken at a clock edge where start is high and busy is low. busy
// stays high until the result is out. The result (status_o, alloc_address_o,
// free_total_o, used_total_o) is shown for exactly one cycle with done_o
// high; the receiver cannot hold it off. A new start may be given in that
// same cycle.
// With N the block count (up to MaxBlocks), every beat but a zero-size
// allocate scans all N table entries; a merge or a split then moves the
// entries above the chosen block through the table memory. A beat's run
// time is set by the single-port table scan and this entry move loop. A
// zero-size allocate fails without a scan.
// Reset, and any write of heap_bytes, rebuilds the table to one free block;
// busy is high while it does so. heap_base writes take effect at once.
// Configure only while idle.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_core #(
  parameter int unsigned MaxBlocks     = bfha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HeaderBytes   = bfha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned AlignBytes    = bfha_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned MinBlockBytes = bfha_pkg::MIN_BLOCK_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [bfha_pkg::AddrW-1:0]     cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [bfha_pkg::SizeW-1:0]     req_bytes_i,
  input  logic [bfha_pkg::AddrW-1:0]     address_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [bfha_pkg::AddrW-1:0]     alloc_address_o,
  output logic [bfha_pkg::SizeW-1:0]     free_total_o,
  output logic [bfha_pkg::SizeW-1:0]     used_total_o
);
  import bfha_pkg::*;
  `include "best_fit_heap_allocator_core_defines.svh"

  localparam int unsigned IW = $clog2(MaxBlocks);
  localparam int unsigned CW = $clog2(MaxBlocks + 1);
  localparam int unsigned NW = SizeW + 2;

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_DEC   = 11'b00000001000,
    S_SU_RD = 11'b00000010000,
    S_SU_WR = 11'b00000100000,
    S_WR_A  = 11'b00001000000,
    S_WR_B  = 11'b00010000000,
    S_SD_RD = 11'b00100000000,
    S_SD_WR = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q;

  logic [AddrW-1:0] base_q;
  logic [SizeW-1:0] hbytes_q;
  logic [CW-1:0]    count_q;
  logic [SizeW-1:0] free_q, used_q;

  logic             op_q;
  logic [NW-1:0]    need_q;
  logic [AddrW-1:0] addr_q;

  logic [CW-1:0]    rd_idx_q;
  logic             pend_q;
  logic [IW-1:0]    pend_idx_q;
  ent_t             last_q;

  logic             found_q;
  logic [IW-1:0]    best_q;
  ent_t             best_e_q;
  logic             has_prev_q, has_next_q;
  ent_t             prev_e_q, next_e_q;

  logic [CW-1:0]    j_q, lim_q;
  logic [1:0]       k_q;
  logic             wb_en_q, down_en_q;
  logic [IW-1:0]    wa_idx_q, wb_idx_q;
  ent_t             wa_e_q, wb_e_q;

  logic             done_q;
  logic [1:0]       status_q;
  logic [AddrW-1:0] out_addr_q;

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  ent_t             mem_wdata, mem_rdata;

  logic [NW-1:0]    req_rnd;
  logic [NW-1:0]    need_d;
  logic [SizeW-1:0] init_size;
  logic [AddrW-1:0] ent_addr;
  logic [CW-1:0]    j_up, src_dn;

  // round the request up to the alignment
  assign req_rnd  = NW'(req_bytes_i) + NW'(AlignBytes - 1);
  assign need_d   = (req_rnd / NW'(AlignBytes)) * NW'(AlignBytes);

  assign init_size = (hbytes_q > SizeW'(HeaderBytes)) ?
                     hbytes_q - SizeW'(HeaderBytes) : '0;
  assign ent_addr  = base_q + AddrW'(mem_rdata.off) + AddrW'(HeaderBytes);
  assign j_up      = j_q + CW'(1);
  assign src_dn    = j_q - CW'(k_q);

  // drive the table ports from the current state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = wa_e_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{off: '0, size: init_size, used: 1'b0};
      end
      S_SCAN: begin
        mem_re    = (rd_idx_q < count_q);
        mem_raddr = rd_idx_q[IW-1:0];
      end
      S_SU_RD, S_SD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = j_q[IW-1:0];
      end
      S_SU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_up[IW-1:0];
        mem_wdata = mem_rdata;
      end
      S_SD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = src_dn[IW-1:0];
        mem_wdata = mem_rdata;
      end
      S_WR_A: begin
        mem_we    = 1'b1;
        mem_waddr = wa_idx_q;
        mem_wdata = wa_e_q;
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = wb_idx_q;
        mem_wdata = wb_e_q;
      end
      default: begin
      end
    endcase
  end

  bfha_mem #(.MaxBlocks(MaxBlocks)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequence one beat through scan, decide, move and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      base_q   <= '0;
      hbytes_q <= HeapBytesRst;
      count_q  <= CW'(1);
      free_q   <= '0;
      used_q   <= '0;
      done_q   <= 1'b0;
      pend_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      done_q <= 1'b0;
      // a heap size write rebuilds the table
      if (cfg_we_i && cfg_idx_i == CFG_HEAP_BYTES) begin
        state_q <= S_INIT;
      end else begin
        unique case (state_q)
          S_INIT: begin
            count_q <= CW'(1);
            free_q  <= init_size;
            used_q  <= '0;
            state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (start) begin
              op_q       <= operation_i;
              need_q     <= need_d;
              addr_q     <= address_i;
              rd_idx_q   <= '0;
              pend_q     <= 1'b0;
              found_q    <= 1'b0;
              has_prev_q <= 1'b0;
              has_next_q <= 1'b0;
              out_addr_q <= '0;
              if (operation_i == OP_ALLOC && req_bytes_i == '0) begin
                status_q <= ST_FAIL;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            // evaluate the entry read last cycle
            if (pend_q) begin
              last_q <= mem_rdata;
              if (op_q == OP_ALLOC) begin
                if (!mem_rdata.used && NW'(mem_rdata.size) >= need_q &&
                    (!found_q || mem_rdata.size < best_e_q.size)) begin
                  found_q  <= 1'b1;
                  best_q   <= pend_idx_q;
                  best_e_q <= mem_rdata;
                end
              end else if (!found_q) begin
                if (mem_rdata.used && ent_addr == addr_q) begin
                  found_q    <= 1'b1;
                  best_q     <= pend_idx_q;
                  best_e_q   <= mem_rdata;
                  prev_e_q   <= last_q;
                  has_prev_q <= (pend_idx_q != '0);
                end
              end else if ((CW'(pend_idx_q)) == CW'(best_q) + CW'(1)) begin
                next_e_q   <= mem_rdata;
                has_next_q <= 1'b1;
              end
            end
            // issue the next read
            if (rd_idx_q < count_q) begin
              pend_q     <= 1'b1;
              pend_idx_q <= rd_idx_q[IW-1:0];
              rd_idx_q   <= rd_idx_q + CW'(1);
            end else begin
              pend_q <= 1'b0;
              if (!pend_q) begin
                state_q <= S_DEC;
              end
            end
          end
          S_DEC: begin
            wb_en_q   <= 1'b0;
            down_en_q <= 1'b0;
            if (!found_q) begin
              status_q <= (op_q == OP_ALLOC) ? ST_FAIL : ST_IGNORED;
              state_q  <= S_DONE;
            end else if (op_q == OP_ALLOC) begin
              status_q   <= ST_OK;
              out_addr_q <= base_q + AddrW'(best_e_q.off) + AddrW'(HeaderBytes);
              if (count_q < CW'(MaxBlocks) &&
                  NW'(best_e_q.size) >= need_q + NW'(HeaderBytes) + NW'(MinBlockBytes)) begin
                // split: insert the remainder after the chosen block
                wa_idx_q <= IW'(CW'(best_q) + CW'(1));
                wa_e_q   <= '{off:  best_e_q.off + SizeW'(HeaderBytes) + SizeW'(need_q),
                              size: best_e_q.size - SizeW'(need_q) - SizeW'(HeaderBytes),
                              used: 1'b0};
                wb_en_q  <= 1'b1;
                wb_idx_q <= best_q;
                wb_e_q   <= '{off: best_e_q.off, size: SizeW'(need_q), used: 1'b1};
                free_q   <= free_q - SizeW'(need_q) - SizeW'(HeaderBytes);
                used_q   <= used_q + SizeW'(need_q);
                j_q      <= count_q - CW'(1);
                lim_q    <= CW'(best_q) + CW'(1);
                count_q  <= count_q + CW'(1);
                state_q  <= S_SU_RD;
              end else begin
                wa_idx_q <= best_q;
                wa_e_q   <= '{off: best_e_q.off, size: best_e_q.size, used: 1'b1};
                free_q   <= free_q - best_e_q.size;
                used_q   <= used_q + best_e_q.size;
                state_q  <= S_WR_A;
              end
            end else begin
              status_q <= ST_OK;
              used_q   <= used_q - best_e_q.size;
              lim_q    <= count_q;
              state_q  <= S_WR_A;
              if (has_prev_q && !prev_e_q.used && has_next_q && !next_e_q.used) begin
                // merge with both neighbors, drop two entries
                wa_idx_q  <= best_q - IW'(1);
                wa_e_q    <= '{off: prev_e_q.off,
                               size: prev_e_q.size + best_e_q.size + next_e_q.size
                                     + SizeW'(2 * HeaderBytes),
                               used: 1'b0};
                free_q    <= free_q + best_e_q.size + SizeW'(2 * HeaderBytes);
                down_en_q <= 1'b1;
                k_q       <= 2'd2;
                j_q       <= CW'(best_q) + CW'(2);
                count_q   <= count_q - CW'(2);
              end else if (has_prev_q && !prev_e_q.used) begin
                wa_idx_q  <= best_q - IW'(1);
                wa_e_q    <= '{off: prev_e_q.off,
                               size: prev_e_q.size + best_e_q.size + SizeW'(HeaderBytes),
                               used: 1'b0};
                free_q    <= free_q + best_e_q.size + SizeW'(HeaderBytes);
                down_en_q <= 1'b1;
                k_q       <= 2'd1;
                j_q       <= CW'(best_q) + CW'(1);
                count_q   <= count_q - CW'(1);
              end else if (has_next_q && !next_e_q.used) begin
                wa_idx_q  <= best_q;
                wa_e_q    <= '{off: best_e_q.off,
                               size: best_e_q.size + next_e_q.size + SizeW'(HeaderBytes),
                               used: 1'b0};
                free_q    <= free_q + best_e_q.size + SizeW'(HeaderBytes);
                down_en_q <= 1'b1;
                k_q       <= 2'd1;
                j_q       <= CW'(best_q) + CW'(2);
                count_q   <= count_q - CW'(1);
              end else begin
                wa_idx_q <= best_q;
                wa_e_q   <= '{off: best_e_q.off, size: best_e_q.size, used: 1'b0};
                free_q   <= free_q + best_e_q.size;
              end
            end
          end
          // move entries up by one, top first
          S_SU_RD: begin
            if (j_q >= lim_q) begin
              state_q <= S_SU_WR;
            end else begin
              state_q <= S_WR_A;
            end
          end
          S_SU_WR: begin
            j_q     <= j_q - CW'(1);
            state_q <= S_SU_RD;
          end
          S_WR_A: begin
            if (wb_en_q) begin
              state_q <= S_WR_B;
            end else if (down_en_q) begin
              state_q <= S_SD_RD;
            end else begin
              state_q <= S_DONE;
            end
          end
          S_WR_B: begin
            state_q <= S_DONE;
          end
          // move entries down by k, bottom first
          S_SD_RD: begin
            if (j_q < lim_q) begin
              state_q <= S_SD_WR;
            end else begin
              state_q <= S_DONE;
            end
          end
          S_SD_WR: begin
            j_q     <= j_q + CW'(1);
            state_q <= S_SD_RD;
          end
          S_DONE: begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
          default: begin
            state_q <= S_INIT;
          end
        endcase
      end

      // configuration register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_BASE) begin
          base_q <= cfg_wdata_i;
        end else begin
          hbytes_q <= cfg_wdata_i[SizeW-1:0];
        end
      end
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign alloc_address_o = out_addr_q;
  assign free_total_o    = free_q;
  assign used_total_o    = used_q;

  `BFHA_ASSERT(a_count_range, (count_q != '0) && (count_q <= CW'(MaxBlocks)), "block count out of range")
  `BFHA_ASSERT(a_done_pulse, done_q |=> !done_q, "result strobe longer than one cycle")
  `BFHA_ASSERT(a_start_busy, (start && !busy && !cfg_we_i) |=> busy, "accepted beat did not raise busy")
  `BFHA_ASSERT(a_fail_addr, (done_q && (status_q != ST_OK)) |-> (out_addr_q == '0), "failed beat with address")

endmodule
